// ===== design/hbd2_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hbd2_pkg;

    localparam int TAP_COUNT    = 31;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 18;

    localparam int HALF_TAPS = TAP_COUNT / 2;
    localparam int STEP_W    = $clog2(TAP_COUNT);
    localparam int WARM_W    = $clog2(HALF_TAPS + 1);
    localparam int FLUSH_W   = $clog2(HALF_TAPS + 1);
    localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W     = PROD_W + $clog2(TAP_COUNT) + 1;

    localparam logic [STEP_W-1:0]  STEP_LAST  = STEP_W'(TAP_COUNT - 1);
    localparam logic [WARM_W-1:0]  WARM_FULL  = WARM_W'(HALF_TAPS);
    localparam logic [FLUSH_W-1:0] FLUSH_LAST = FLUSH_W'(HALF_TAPS - 1);
    // An output due at one of the last two flush pushes is the last one of the stream.
    localparam logic [FLUSH_W-1:0] FLUSH_FINAL_FROM = FLUSH_W'(HALF_TAPS - 2);
    // The output is due when the centre sample index is even.
    localparam logic DUE_PHASE = 1'(HALF_TAPS % 2);

    // Half-band taps in Q1.17, normalized to unity DC gain and scaled by sqrt(2).
    localparam logic signed [COEF_WIDTH-1:0] HB_COEF [TAP_COUNT] = '{
        -18'sd24,    18'sd0, 18'sd202,    18'sd0, -18'sd789,   18'sd0,
        18'sd2229,   18'sd0, -18'sd5176,  18'sd0, 18'sd10609, 18'sd0,
        -18'sd21280, 18'sd0, 18'sd68014, 18'sd77794, 18'sd68014,
        18'sd0, -18'sd21280, 18'sd0, 18'sd10609, 18'sd0, -18'sd5176,
        18'sd0, 18'sd2229,   18'sd0, -18'sd789,  18'sd0, 18'sd202,
        18'sd0, -18'sd24
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic push;
        logic rotate;
        logic zero_in;
        logic clear;
    } t_tap_ctrl;

    typedef struct packed {
        logic              clear;
        logic              mul_en;
        logic [STEP_W-1:0] step;
    } t_mac_ctrl;

endpackage

`default_nettype wire

// ===== design/hbd2_taps.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Delay line. A push shifts a new sample in at the head; a rotate moves the
// tail back to the head, so after a full lap the line is as it was.
module hbd2_taps (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire hbd2_pkg::t_tap_ctrl                        i_ctrl,
    input  wire logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0]   i_sample,
    output logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0]        o_tail
);

    logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0] r_tap [hbd2_pkg::TAP_COUNT];
    logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0] n_tap [hbd2_pkg::TAP_COUNT];

    always_comb begin
        n_tap = r_tap;
        if (i_ctrl.clear) begin
            for (int k = 0; k < hbd2_pkg::TAP_COUNT; k++) begin
                n_tap[k] = '0;
            end
        end else if (i_ctrl.push || i_ctrl.rotate) begin
            for (int k = 1; k < hbd2_pkg::TAP_COUNT; k++) begin
                n_tap[k] = r_tap[k-1];
            end
            if (i_ctrl.rotate) begin
                n_tap[0] = r_tap[hbd2_pkg::TAP_COUNT-1];
            end else if (i_ctrl.zero_in) begin
                n_tap[0] = '0;
            end else begin
                n_tap[0] = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hbd2_pkg::TAP_COUNT; k++) begin
                r_tap[k] <= '0;
            end
        end else begin
            r_tap <= n_tap;
        end
    end

    assign o_tail = r_tap[hbd2_pkg::TAP_COUNT-1];

endmodule

`default_nettype wire

// ===== design/hbd2_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared multiply-accumulate unit with round-half-up and saturation on the sum.
module hbd2_mac (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire hbd2_pkg::t_mac_ctrl                        i_ctrl,
    input  wire logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0]   i_tap,
    output logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0]        o_result
);

    localparam int ACC_W = hbd2_pkg::ACC_W;
    localparam int SHIFT = hbd2_pkg::COEF_WIDTH - 1;
    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(2 ** (SHIFT - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'(2 ** (hbd2_pkg::SAMPLE_WIDTH - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        -ACC_W'(2 ** (hbd2_pkg::SAMPLE_WIDTH - 1));

    logic signed [hbd2_pkg::PROD_W-1:0] r_prod;
    logic                               r_prod_vld;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [ACC_W-1:0]            n_acc;
    logic signed [ACC_W-1:0]            rounded;
    logic signed [ACC_W-1:0]            scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_tap * hbd2_pkg::HB_COEF[i_ctrl.step];
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (r_prod_vld) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_comb begin
        rounded = r_acc + ROUND_ADD;
        scaled  = rounded >>> SHIFT;
        if (scaled > SAT_MAX) begin
            o_result = SAT_MAX[hbd2_pkg::SAMPLE_WIDTH-1:0];
        end else if (scaled < SAT_MIN) begin
            o_result = SAT_MIN[hbd2_pkg::SAMPLE_WIDTH-1:0];
        end else begin
            o_result = scaled[hbd2_pkg::SAMPLE_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/hbd2_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: tracks warm-up and phase, steps the MAC over the taps and runs the flush.
module hbd2_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_end_of_stream,
    input  wire logic             i_out_free,
    output logic                  o_ready,
    output logic                  o_load,
    output logic                  o_final,
    output hbd2_pkg::t_tap_ctrl   o_tap_ctrl,
    output hbd2_pkg::t_mac_ctrl   o_mac_ctrl
);

    hbd2_pkg::t_state                  r_state, n_state;
    logic [hbd2_pkg::STEP_W-1:0]       r_step, n_step;
    logic [hbd2_pkg::WARM_W-1:0]       r_warm, n_warm;
    logic                              r_phase, n_phase;
    logic [hbd2_pkg::FLUSH_W-1:0]      r_flush, n_flush;
    logic                              r_eos, n_eos;
    logic                              r_final, n_final;
    logic                              due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbd2_pkg::S_IDLE;
            r_step  <= '0;
            r_warm  <= '0;
            r_phase <= 1'b0;
            r_flush <= '0;
            r_eos   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_warm  <= n_warm;
            r_phase <= n_phase;
            r_flush <= n_flush;
            r_eos   <= n_eos;
            r_final <= n_final;
        end
    end

    assign due = (r_warm == hbd2_pkg::WARM_FULL) && (r_phase == hbd2_pkg::DUE_PHASE);

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_warm     = r_warm;
        n_phase    = r_phase;
        n_flush    = r_flush;
        n_eos      = r_eos;
        n_final    = r_final;
        o_ready    = 1'b0;
        o_load     = 1'b0;
        o_tap_ctrl = '0;
        o_mac_ctrl = '{clear: 1'b0, mul_en: 1'b0, step: r_step};

        unique case (r_state)
            hbd2_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_tap_ctrl.push = 1'b1;
                    n_phase = ~r_phase;
                    if (r_warm != hbd2_pkg::WARM_FULL) begin
                        n_warm = r_warm + 1'b1;
                    end
                    n_eos   = i_end_of_stream;
                    n_flush = '0;
                    n_final = 1'b0;
                    if (due) begin
                        o_mac_ctrl.clear = 1'b1;
                        n_step  = '0;
                        n_state = hbd2_pkg::S_MAC;
                    end else if (i_end_of_stream) begin
                        n_state = hbd2_pkg::S_FLUSH;
                    end
                end
            end
            hbd2_pkg::S_FLUSH: begin
                o_tap_ctrl.push    = 1'b1;
                o_tap_ctrl.zero_in = 1'b1;
                n_phase = ~r_phase;
                if (r_warm != hbd2_pkg::WARM_FULL) begin
                    n_warm = r_warm + 1'b1;
                end
                n_flush = r_flush + 1'b1;
                if (due) begin
                    o_mac_ctrl.clear = 1'b1;
                    n_step  = '0;
                    n_final = (r_flush >= hbd2_pkg::FLUSH_FINAL_FROM);
                    n_state = hbd2_pkg::S_MAC;
                end else if (r_flush == hbd2_pkg::FLUSH_LAST) begin
                    o_tap_ctrl.clear = 1'b1;
                    n_warm  = '0;
                    n_phase = 1'b0;
                    n_eos   = 1'b0;
                    n_state = hbd2_pkg::S_IDLE;
                end
            end
            hbd2_pkg::S_MAC: begin
                o_tap_ctrl.rotate = 1'b1;
                o_mac_ctrl.mul_en = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == hbd2_pkg::STEP_LAST) begin
                    n_step  = '0;
                    n_state = hbd2_pkg::S_DRAIN;
                end
            end
            hbd2_pkg::S_DRAIN: begin
                n_state = hbd2_pkg::S_OUT;
            end
            hbd2_pkg::S_OUT: begin
                if (i_out_free) begin
                    o_load = 1'b1;
                    if (r_final) begin
                        // The last result of the stream clears the block for a new one.
                        o_tap_ctrl.clear = 1'b1;
                        n_warm  = '0;
                        n_phase = 1'b0;
                        n_eos   = 1'b0;
                        n_final = 1'b0;
                        n_state = hbd2_pkg::S_IDLE;
                    end else if (r_eos) begin
                        n_state = hbd2_pkg::S_FLUSH;
                    end else begin
                        n_state = hbd2_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = hbd2_pkg::S_IDLE;
            end
        endcase
    end

    assign o_final = r_final;

    a_no_push_in_lap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_tap_ctrl.push && o_tap_ctrl.rotate))
        else $error("delay line pushed during a MAC lap");

    a_out_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbd2_pkg::S_OUT && $past(r_state) != hbd2_pkg::S_OUT)
        |-> $past(r_state) == hbd2_pkg::S_DRAIN)
        else $error("result presented without a full accumulation");

    a_final_only_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_final |-> r_eos)
        else $error("final flag set outside a flush");

    a_lap_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbd2_pkg::S_MAC && $past(r_state) != hbd2_pkg::S_MAC)
        |-> r_step == '0)
        else $error("MAC lap did not start at the first tap");

endmodule

`default_nettype wire

// ===== design/halfband_decimate_by_two_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Half-band decimate-by-two filter for signed Q1.15 audio. Each accepted
// request pushes one sample into a 31-entry delay line; at every second
// sample, once fifteen samples have been seen, a 31-tap half-band lowpass
// (Q1.17 taps) is evaluated and one Q1.15 result, rounded half up and
// saturated, is returned. A request marked end_of_stream flushes the filter
// with fifteen zero samples, returns the pending results (up to eight in all
// for that request), flags the last with final_out and clears the block for a
// new stream. A request that produces no result only pushes its sample. One
// that does is followed, before the next request is taken, by a lap in which a
// single shared multiplier walks the 31 taps one per cycle while the delay line
// rotates past it, a drain step that finishes the sum and a load of the output
// register once that register is free. A flush pushes its zero samples one by
// one and runs the same lap, drain and load for each flushed result. The output
// register holds a finished result while the filter goes on with the next one.
module halfband_decimate_by_two_unit (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_valid,
    output logic                                            o_ready,
    input  wire logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0]   i_sample_in,
    input  wire logic                                       i_end_of_stream,
    output logic                                            o_valid,
    input  wire logic                                       i_ready,
    output logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0]        o_sample_out,
    output logic                                            o_final_out
);

    hbd2_pkg::t_tap_ctrl                      tap_ctrl;
    hbd2_pkg::t_mac_ctrl                      mac_ctrl;
    logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0] tail;
    logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0] result;
    logic                                     load;
    logic                                     final_flag;
    logic                                     out_free;

    logic                                     r_out_valid;
    logic signed [hbd2_pkg::SAMPLE_WIDTH-1:0] r_out_sample;
    logic                                     r_out_final;

    // The output register can take a new result when it is empty or being drained.
    assign out_free = !r_out_valid || i_ready;

    hbd2_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_end_of_stream (i_end_of_stream),
        .i_out_free      (out_free),
        .o_ready         (o_ready),
        .o_load          (load),
        .o_final         (final_flag),
        .o_tap_ctrl      (tap_ctrl),
        .o_mac_ctrl      (mac_ctrl)
    );

    hbd2_taps u_taps (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (tap_ctrl),
        .i_sample (i_sample_in),
        .o_tail   (tail)
    );

    hbd2_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_tap    (tail),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_sample <= result;
            r_out_final  <= final_flag;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_final_out  = r_out_final;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> out_free)
        else $error("result loaded over one not yet taken");

    a_busy_while_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !o_ready)
        else $error("request taken while a result is being loaded");

    a_quiet_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && final_flag) |=> !load)
        else $error("result produced right after the end of a stream");

endmodule

`default_nettype wire

// ===== bench/tb_halfband_decimate_by_two_unit.sv =====
`timescale 1ns / 1ps

module tb_halfband_decimate_by_two_unit;

    // Filter dimensions from the design package.
    localparam int TAP_COUNT    = hbd2_pkg::TAP_COUNT;
    localparam int SAMPLE_WIDTH = hbd2_pkg::SAMPLE_WIDTH;
    localparam int HALF_TAPS    = hbd2_pkg::HALF_TAPS;

    // Clock period halves, in ns.
    localparam int CLK_HIGH = 5;
    localparam int CLK_LOW  = 5;
    localparam int RESET_CYCLES = 8;

    // Random part of the run, counted in requests.
    localparam int RANDOM_REQUESTS = 85;
    // Longest idle stretch either side draws before a handshake.
    localparam int MAX_IDLE = 14;
    // The receiver refuses results for this long once this many have arrived.
    localparam int HOLD_AT_RESULT = 40;
    localparam int HOLD_CYCLES    = 400;
    // Wait at the end a little longer than a result takes inside the block.
    localparam int SETTLE_CYCLES = 60;
    // Watchdog time in ns, many times the slowest correct run.
    localparam int WATCHDOG_NS = 5_000_000;

    localparam int DIRECTED_ROWS = 23;

    // Fixed-point constants of the filter: Q1.17 taps, rounding to Q1.15.
    localparam int     FRAC_SHIFT = 17;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_SHIFT - 1);
    localparam longint SAT_MAX    = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAT_MIN    = -SAT_MAX - 1;

    // Half-band taps in Q1.17; every odd tap but the centre is zero.
    localparam int HB_TAP_Q17 [TAP_COUNT] = '{
        -24, 0, 202, 0, -789, 0, 2229, 0, -5176, 0, 10609, 0, -21280, 0, 68014,
        77794,
        68014, 0, -21280, 0, 10609, 0, -5176, 0, 2229, 0, -789, 0, 202, 0, -24
    };

    // Ways of filling the samples of one random stream.
    typedef enum int {
        FILL_FULL_RANGE,
        FILL_SMALL,
        FILL_EXTREMES,
        FILL_CONSTANT
    } t_fill;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           eos;
        // When set, the single result of this request is the one typed in the row.
        logic                           typed;
        logic signed [SAMPLE_WIDTH-1:0] want_sample;
        logic                           want_fin;
    } t_request;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           fin;
    } t_decimated;

    // Block ports. Every input has a known value from time zero.
    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_valid         = 1'b0;
    logic                           o_ready;
    logic signed [SAMPLE_WIDTH-1:0] i_sample_in     = '0;
    logic                           i_end_of_stream = 1'b0;
    logic                           o_valid;
    logic                           i_ready         = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] o_sample_out;
    logic                           o_final_out;

    // Model of the filter state: delay line (entry 0 newest), warm-up count and parity.
    logic signed [SAMPLE_WIDTH-1:0] model_taps [TAP_COUNT];
    int unsigned                    model_warm;
    logic                           model_phase;

    // Results of the request being predicted, then the queue of all outstanding ones.
    t_decimated step_outputs [$];
    t_decimated pending_outputs [$];
    t_request   request_list [$];

    int error_count    = 0;
    int results_taken  = 0;

    halfband_decimate_by_two_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_in     (i_sample_in),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample_out    (o_sample_out),
        .o_final_out     (o_final_out)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // Every mismatch goes through here: one line, one count.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Clear the model to its state after reset.
    task automatic clear_filter_model();
        foreach (model_taps[k]) begin
            model_taps[k] = '0;
        end
        model_warm  = 0;
        model_phase = 1'b0;
    endtask

    // Convolve the delay line with the taps, round half up to Q1.15 and saturate.
    function automatic logic signed [SAMPLE_WIDTH-1:0] filter_output();
        longint acc;
        longint q;
        acc = 0;
        for (int k = 0; k < TAP_COUNT; k++) begin
            acc += longint'(model_taps[k]) * longint'(HB_TAP_Q17[TAP_COUNT-1-k]);
        end
        // An arithmetic shift is a floor division, so this rounds half up.
        q = (acc + ROUND_HALF) >>> FRAC_SHIFT;
        if (q > SAT_MAX) begin
            q = SAT_MAX;
        end
        if (q < SAT_MIN) begin
            q = SAT_MIN;
        end
        return q[SAMPLE_WIDTH-1:0];
    endfunction

    // Shift one sample into the model. A result falls due once the delay line has
    // warmed up, and then only where the centre sample has an even index.
    task automatic shift_in_sample(input logic signed [SAMPLE_WIDTH-1:0] x);
        t_decimated res;
        for (int k = TAP_COUNT - 1; k > 0; k--) begin
            model_taps[k] = model_taps[k-1];
        end
        model_taps[0] = x;
        if (model_warm >= HALF_TAPS && model_phase == 1'(HALF_TAPS % 2)) begin
            res.sample = filter_output();
            res.fin    = 1'b0;
            step_outputs.push_back(res);
        end
        model_phase = ~model_phase;
        if (model_warm < HALF_TAPS) begin
            model_warm++;
        end
    endtask

    // Predict the decimated results of one accepted request into step_outputs.
    // The end of a stream feeds fifteen zeros, flags the last result as final and
    // leaves the filter cleared for the next stream.
    task automatic predict_decimated(input logic signed [SAMPLE_WIDTH-1:0] x,
                                     input logic eos);
        step_outputs.delete();
        shift_in_sample(x);
        if (eos) begin
            for (int k = 0; k < HALF_TAPS; k++) begin
                shift_in_sample('0);
            end
            if (step_outputs.size() > 0) begin
                step_outputs[step_outputs.size()-1].fin = 1'b1;
            end
            clear_filter_model();
        end
    endtask

    // Draw one sample for a random stream in the given fill style.
    function automatic logic signed [SAMPLE_WIDTH-1:0] draw_sample(
            input t_fill fill, input logic signed [SAMPLE_WIDTH-1:0] level);
        int small_val;
        small_val = int'($urandom_range(0, 600)) - 300;
        case (fill)
            FILL_FULL_RANGE: return SAMPLE_WIDTH'($urandom);
            FILL_SMALL:      return small_val[SAMPLE_WIDTH-1:0];
            FILL_EXTREMES:   return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            default:         return level;
        endcase
    endfunction

    // Fill the request list: the directed table first, then random streams. Each
    // random stream has a random length and fill style and ends on a marked sample,
    // so most of the run goes through warm-up, steady decimation and a flush.
    task automatic build_requests();
        t_request directed [DIRECTED_ROWS];
        t_request req;
        t_fill    fill;
        logic signed [SAMPLE_WIDTH-1:0] level;
        int       stream_len;
        int       made;

        // A lone sample ends up on the centre tap, so its one result is the sample
        // times the centre tap. Then a ten-sample stream at each full-scale value,
        // which drives the flushed results into saturation at both ends.
        directed = '{
            '{16'sd0,      1'b1, 1'b1, 16'sd0,      1'b1},
            '{16'sh7FFF,   1'b1, 1'b1, 16'sd19448,  1'b1},
            '{16'sh8000,   1'b1, 1'b1, -16'sd19448, 1'b1},
            '{16'sh7FFF,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh7FFF,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh7FFF,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh7FFF,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh7FFF,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh7FFF,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh7FFF,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh7FFF,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh7FFF,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh7FFF,   1'b1, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
            '{16'sh8000,   1'b1, 1'b0, 16'sd0,      1'b0}
        };
        foreach (directed[r]) begin
            request_list.push_back(directed[r]);
        end

        made = 0;
        while (made < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 9))
                0:       stream_len = $urandom_range(1, 3);
                1, 2:    stream_len = $urandom_range(25, 60);
                default: stream_len = $urandom_range(4, 24);
            endcase
            fill  = t_fill'($urandom_range(0, 3));
            level = SAMPLE_WIDTH'($urandom);
            for (int s = 0; s < stream_len; s++) begin
                req.sample      = draw_sample(fill, level);
                req.eos         = (s == stream_len - 1);
                req.typed       = 1'b0;
                req.want_sample = '0;
                req.want_fin    = 1'b0;
                request_list.push_back(req);
            end
            made += stream_len;
        end
    endtask

    // Watchdog: a run that hangs ends here as a failure.
    initial begin
        #WATCHDOG_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sender: applies reset once, then offers every request in turn. Valid stays up
    // with a fixed payload until the block accepts, and the model is advanced at the
    // accepting edge. Every few dozen requests it runs a stretch with no idling.
    initial begin
        int gap;
        t_request req;

        clear_filter_model();
        build_requests();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < request_list.size(); idx++) begin
            req = request_list[idx];
            gap = ((idx % 37) < 10) ? 0 : $urandom_range(0, MAX_IDLE);
            // Dropping valid only when there is a gap means it is never lowered and
            // raised again at one edge.
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid         <= 1'b1;
            i_sample_in     <= req.sample;
            i_end_of_stream <= req.eos;
            // Signals read just after the edge still hold their values from before
            // it, so this tests the handshake the block saw at that edge.
            @(posedge i_clk);
            while (!o_ready) begin
                @(posedge i_clk);
            end
            predict_decimated(req.sample, req.eos);
            if (req.typed) begin
                pending_outputs.push_back('{req.want_sample, req.want_fin});
            end else begin
                foreach (step_outputs[k]) begin
                    pending_outputs.push_back(step_outputs[k]);
                end
            end
        end
        i_valid <= 1'b0;

        // Wait for every outstanding result, then long enough for a stray one to show.
        while (pending_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Receiver: draws a stall before every result, has runs with no stall, and once
    // holds ready low for a long stretch so that the block backs up and stalls its
    // request side. Each taken result is checked against the oldest expectation.
    initial begin
        int gap;
        t_decimated want;

        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end

        forever begin
            if (results_taken == HOLD_AT_RESULT) begin
                gap = HOLD_CYCLES;
            end else if ((results_taken % 23) < 8) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, MAX_IDLE);
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) begin
                @(posedge i_clk);
            end
            results_taken++;
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result sample=%0d final=%0b",
                                          o_sample_out, o_final_out));
            end else begin
                want = pending_outputs.pop_front();
                if (o_sample_out !== want.sample) begin
                    report_mismatch($sformatf("result %0d sample_out got %0d want %0d",
                                              results_taken, o_sample_out, want.sample));
                end
                if (o_final_out !== want.fin) begin
                    report_mismatch($sformatf("result %0d final_out got %0b want %0b",
                                              results_taken, o_final_out, want.fin));
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
design/hbd2_pkg.sv
design/hbd2_taps.sv
design/hbd2_mac.sv
design/hbd2_seq.sv
design/halfband_decimate_by_two_unit.sv
bench/tb_halfband_decimate_by_two_unit.sv
